FILE: design/lr_pkg.sv
// Shared types and constants for the line rasterizer.
`default_nettype none

package lr_pkg;

  // Coordinate and length widths.
  localparam int COORD_BITS  = 12;
  localparam int LEN_BITS    = COORD_BITS + 1;
  localparam int CFG_BITS    = 12;
  localparam int COLOUR_BITS = 32;
  localparam int CMP_BITS    = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;

  // Depth of the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Reset values of the image size registers.
  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(1024);
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(1024);

  // Item actions.
  typedef enum logic [0:0] {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Input item.
  typedef struct packed {
    logic                          action;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  end_x;
    logic signed [COORD_BITS-1:0]  end_y;
    logic        [COLOUR_BITS-1:0] line_colour;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic signed [COORD_BITS-1:0]  pixel_x;
    logic signed [COORD_BITS-1:0]  pixel_y;
    logic        [COLOUR_BITS-1:0] pixel_colour;
    logic                          inside_res;
    logic                          last;
  } out_item_t;

  // Classified command from the front to the back.
  typedef struct packed {
    logic                          is_start;
    logic        [COORD_BITS-1:0]  x0;
    logic        [COORD_BITS-1:0]  y0;
    logic        [COORD_BITS-1:0]  major_len;
    logic        [COORD_BITS-1:0]  minor_len;
    logic signed [1:0]             diag_x;
    logic signed [1:0]             diag_y;
    logic signed [1:0]             axis_x;
    logic signed [1:0]             axis_y;
    logic        [COLOUR_BITS-1:0] colour;
  } cmd_t;

  // Handshake between the queue and its neighbors.
  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

`default_nettype wire

FILE: design/lr_front.sv
// Front end: accepts items, classifies them and works out the octant setup.
`default_nettype none

module lr_front (
  input  wire  lr_pkg::in_item_t      in_item,
  input  wire  logic                  in_valid,
  output logic                        in_stall,
  input  wire  logic                  queue_full,
  output logic                        push,
  output lr_pkg::cmd_t                cmd
);

  localparam int C = lr_pkg::COORD_BITS;

  logic signed [C:0]   dx;
  logic signed [C:0]   dy;
  logic        [C:0]   dx_abs;
  logic        [C:0]   dy_abs;
  logic        [C-1:0] ax;
  logic        [C-1:0] ay;
  logic signed [1:0]   sx;
  logic signed [1:0]   sy;

  // The queue is the only back pressure the front sees.
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Deltas, magnitudes and signs; a zero delta steps in the positive direction.
  always_comb begin
    dx     = {in_item.end_x[C-1], in_item.end_x} - {in_item.start_x[C-1], in_item.start_x};
    dy     = {in_item.end_y[C-1], in_item.end_y} - {in_item.start_y[C-1], in_item.start_y};
    dx_abs = dx[C] ? -dx : dx;
    dy_abs = dy[C] ? -dy : dy;
    ax     = dx_abs[C-1:0];
    ay     = dy_abs[C-1:0];
    sx     = dx[C] ? -2'sd1 : 2'sd1;
    sy     = dy[C] ? -2'sd1 : 2'sd1;
  end

  // Build the command; equal lengths make x the major axis.
  always_comb begin
    cmd.is_start = (in_item.action == lr_pkg::ACT_START);
    cmd.x0       = in_item.start_x;
    cmd.y0       = in_item.start_y;
    cmd.colour   = in_item.line_colour;
    cmd.diag_x   = sx;
    cmd.diag_y   = sy;
    if (ax < ay) begin
      cmd.major_len = ay;
      cmd.minor_len = ax;
      cmd.axis_x    = 2'sd0;
      cmd.axis_y    = sy;
    end else begin
      cmd.major_len = ax;
      cmd.minor_len = ay;
      cmd.axis_x    = sx;
      cmd.axis_y    = 2'sd0;
    end
  end

endmodule

`default_nettype wire

FILE: design/lr_queue.sv
// Short command queue between the front and the back.
`default_nettype none

module lr_queue (
  input  wire  logic                  clk,
  input  wire  logic                  rst,
  input  wire  logic                  push,
  input  wire  lr_pkg::cmd_t          wr_cmd,
  input  wire  logic                  pop,
  output lr_pkg::cmd_t                rd_cmd,
  output lr_pkg::queue_status_t       qstat
);

  localparam int D  = lr_pkg::QUEUE_DEPTH;
  localparam int PB = lr_pkg::QPTR_BITS;
  localparam int CB = lr_pkg::QCNT_BITS;

  lr_pkg::cmd_t  entries [D];
  logic [PB-1:0] wr_ptr;
  logic [PB-1:0] rd_ptr;
  logic [CB-1:0] count;

  assign qstat.full  = (count == CB'(D));
  assign qstat.valid = (count != '0);
  assign rd_cmd      = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PB'(D - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PB'(D - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: design/lr_back.sv
// Back end: walks the active line and emits one pixel per start, and per step while a line is active.
`default_nettype none

module lr_back (
  input  wire  logic                         clk,
  input  wire  logic                         rst,
  input  wire  lr_pkg::cmd_t                 cmd,
  input  wire  logic                         cmd_valid,
  output logic                               pop,
  input  wire  logic [lr_pkg::CFG_BITS-1:0]  image_width,
  input  wire  logic [lr_pkg::CFG_BITS-1:0]  image_height,
  output lr_pkg::out_item_t                  out_item,
  output logic                               out_valid,
  input  wire  logic                         out_stall
);

  localparam int C  = lr_pkg::COORD_BITS;
  localparam int L  = lr_pkg::LEN_BITS;
  localparam int CM = lr_pkg::CMP_BITS;

  // Line state.
  logic                           busy;
  logic        [C-1:0]            cur_x;
  logic        [C-1:0]            cur_y;
  logic        [L-1:0]            pixels_left;
  logic        [L-1:0]            error_acc;
  logic        [C-1:0]            major_len;
  logic        [C-1:0]            minor_len;
  logic signed [1:0]              diag_step_x;
  logic signed [1:0]              diag_step_y;
  logic signed [1:0]              axis_step_x;
  logic signed [1:0]              axis_step_y;
  logic        [lr_pkg::COLOUR_BITS-1:0] held_colour;

  // Values the current pixel is computed from.
  logic        [C-1:0]            base_x;
  logic        [C-1:0]            base_y;
  logic        [L-1:0]            base_left;
  logic        [L-1:0]            base_err;
  logic        [C-1:0]            base_major;
  logic        [C-1:0]            base_minor;
  logic signed [1:0]              base_dx;
  logic signed [1:0]              base_dy;
  logic signed [1:0]              base_ax;
  logic signed [1:0]              base_ay;
  logic        [lr_pkg::COLOUR_BITS-1:0] base_colour;

  logic                           can_advance;
  logic                           emit;
  logic        [L-1:0]            pixels_left_next;
  logic        [L-1:0]            acc_sum;
  logic                           wrap;
  logic        [L-1:0]            error_acc_next;
  logic signed [1:0]              step_x;
  logic signed [1:0]              step_y;
  logic        [C-1:0]            cur_x_next;
  logic        [C-1:0]            cur_y_next;
  logic                           in_image;
  logic                           last_pixel;

  // A command leaves the queue whenever the output register can take a result.
  assign can_advance = !out_valid || !out_stall;
  assign pop         = cmd_valid && can_advance;
  assign emit        = pop && (cmd.is_start || busy);

  // A start loads a fresh line; a step continues the held one.
  always_comb begin
    if (cmd.is_start) begin
      base_x      = cmd.x0;
      base_y      = cmd.y0;
      base_major  = cmd.major_len;
      base_minor  = cmd.minor_len;
      base_left   = L'(cmd.major_len) + 1'b1;
      base_err    = L'(cmd.major_len >> 1);
      base_dx     = cmd.diag_x;
      base_dy     = cmd.diag_y;
      base_ax     = cmd.axis_x;
      base_ay     = cmd.axis_y;
      base_colour = cmd.colour;
    end else begin
      base_x      = cur_x;
      base_y      = cur_y;
      base_major  = major_len;
      base_minor  = minor_len;
      base_left   = pixels_left;
      base_err    = error_acc;
      base_dx     = diag_step_x;
      base_dy     = diag_step_y;
      base_ax     = axis_step_x;
      base_ay     = axis_step_y;
      base_colour = held_colour;
    end
  end

  // Pixel flags and the Bresenham error update.
  always_comb begin
    in_image = !base_x[C-1] && (CM'(base_x) < CM'(image_width)) &&
               !base_y[C-1] && (CM'(base_y) < CM'(image_height));
    pixels_left_next = base_left - 1'b1;
    last_pixel       = (pixels_left_next == '0);
    acc_sum          = base_err + L'(base_minor);
    wrap             = (acc_sum >= L'(base_major));
    error_acc_next   = wrap ? (acc_sum - L'(base_major)) : acc_sum;
    step_x           = wrap ? base_dx : base_ax;
    step_y           = wrap ? base_dy : base_ay;
    cur_x_next       = base_x + {{(C-2){step_x[1]}}, step_x};
    cur_y_next       = base_y + {{(C-2){step_y[1]}}, step_y};
  end

  // Line state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      cur_x       <= '0;
      cur_y       <= '0;
      pixels_left <= '0;
      error_acc   <= '0;
      major_len   <= '0;
      minor_len   <= '0;
      diag_step_x <= '0;
      diag_step_y <= '0;
      axis_step_x <= '0;
      axis_step_y <= '0;
      held_colour <= '0;
    end else if (emit) begin
      busy        <= !last_pixel;
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      pixels_left <= pixels_left_next;
      error_acc   <= error_acc_next;
      major_len   <= base_major;
      minor_len   <= base_minor;
      diag_step_x <= base_dx;
      diag_step_y <= base_dy;
      axis_step_x <= base_ax;
      axis_step_y <= base_ay;
      held_colour <= base_colour;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_advance) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (can_advance && emit) begin
      out_item.pixel_x      <= base_x;
      out_item.pixel_y      <= base_y;
      out_item.pixel_colour <= base_colour;
      out_item.inside_res   <= in_image;
      out_item.last         <= last_pixel;
    end
  end

endmodule

`default_nettype wire

FILE: design/line_rasterizer.sv
// Top level of the line rasterizer: configuration registers, front, queue and back.
`default_nettype none

// Bresenham line rasterizer. A start item (action 0) loads two endpoints and a
// colour and yields the line's first pixel; each step item (action 1) yields the
// next pixel, with last set on the final one and inside_res set when the pixel
// lies within image_width by image_height. A step with no active line yields
// nothing. The block takes one item and gives one pixel every clock cycle while
// the output is not stalled, a rate set by the back end's error update, which
// adds, compares and subtracts once per pixel. An accepted item is written into
// the command queue, and the output register then holds its pixel until it is
// taken. Configuration writes are always taken at once and must only be made
// while the block is idle.
module line_rasterizer (
  input  wire  logic                         clk,
  input  wire  logic                         rst,
  input  wire  lr_pkg::in_item_t             in_item,
  input  wire  logic                         in_valid,
  output logic                               in_stall,
  output lr_pkg::out_item_t                  out_item,
  output logic                               out_valid,
  input  wire  logic                         out_stall,
  input  wire  logic                         cfg_valid,
  output logic                               cfg_ready,
  input  wire  lr_pkg::cfg_reg_t             cfg_index,
  input  wire  logic [lr_pkg::CFG_BITS-1:0]  cfg_data
);

  logic [lr_pkg::CFG_BITS-1:0] image_width;
  logic [lr_pkg::CFG_BITS-1:0] image_height;

  lr_pkg::queue_status_t qstat;
  lr_pkg::cmd_t          push_cmd;
  lr_pkg::cmd_t          head_cmd;
  logic                  push;
  logic                  pop;

  // Image size registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= lr_pkg::WIDTH_RESET;
      image_height <= lr_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lr_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        lr_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lr_front u_front (
    .in_item    (in_item),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .queue_full (qstat.full),
    .push       (push),
    .cmd        (push_cmd)
  );

  lr_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (push_cmd),
    .pop    (pop),
    .rd_cmd (head_cmd),
    .qstat  (qstat)
  );

  lr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (head_cmd),
    .cmd_valid    (qstat.valid),
    .pop          (pop),
    .image_width  (image_width),
    .image_height (image_height),
    .out_item     (out_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

endmodule

`default_nettype wire
